### design/npte_pkg.sv
package npte_pkg;
    localparam int unsigned MAX_POINTS_DEF = 1024;
    localparam int unsigned LEN_W = 11;
    localparam int unsigned IDX_W = 10;
    localparam int unsigned ENTRY_W = 112;
    localparam int unsigned CORDIC_STEPS = 14;
    localparam logic signed [17:0] PI_Q = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q = 18'sd51472;
    localparam logic signed [17:0] HALF_PI_Q = 18'sd12868;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    function automatic logic [12:0] atan_entry(input logic [3:0] i);
        logic [12:0] r;
        begin
            case (i)
                4'd0: r = 13'd6434;
                4'd1: r = 13'd3798;
                4'd2: r = 13'd2007;
                4'd3: r = 13'd1019;
                4'd4: r = 13'd511;
                4'd5: r = 13'd256;
                4'd6: r = 13'd128;
                4'd7: r = 13'd64;
                4'd8: r = 13'd32;
                4'd9: r = 13'd16;
                4'd10: r = 13'd8;
                4'd11: r = 13'd4;
                4'd12: r = 13'd2;
                4'd13: r = 13'd1;
                default: r = 13'd0;
            endcase
            return r;
        end
    endfunction
endpackage

### design/npte_ram.sv
module npte_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/npte_sqrt.sv
// Bit-serial integer square root of a 62-bit value, one result bit a cycle.
module npte_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [61:0] i_value,
    output logic        o_done,
    output logic [30:0] o_root
);
    logic [61:0] r_rem;
    logic [30:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    // Classic restoring method: bring down two bits, try 4*root+1.
    logic [33:0] r_part;
    logic [33:0] w_bring;
    logic [33:0] w_try;
    assign w_bring = {r_part[31:0], r_rem[61:60]};
    assign w_try   = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd30;
                r_rem  <= i_value;
                r_root <= '0;
                r_part <= '0;
            end else if (r_busy) begin
                r_rem <= {r_rem[59:0], 2'b00};
                if (w_bring >= w_try) begin
                    r_part <= w_bring - w_try;
                    r_root <= {r_root[29:0], 1'b1};
                end else begin
                    r_part <= w_bring;
                    r_root <= {r_root[29:0], 1'b0};
                end
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

### design/npte_cordic.sv
// Iterative CORDIC vectoring, one step a cycle, gives the Q2.13 bearing.
module npte_cordic
    import npte_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_dx,
    input  logic signed [32:0] i_dy,
    output logic               o_done,
    output logic signed [17:0] o_bearing
);
    logic signed [35:0] r_x;
    logic signed [35:0] r_y;
    logic signed [17:0] r_z;
    logic [3:0]         r_step;
    logic               r_busy;
    logic               r_done;
    logic               r_dxneg;
    logic               r_dyneg;
    logic               r_zero;
    logic signed [35:0] w_xs;
    logic signed [35:0] w_ys;
    logic signed [17:0] w_zc;
    logic signed [17:0] w_tab;

    assign w_xs  = r_x >>> r_step;
    assign w_ys  = r_y >>> r_step;
    assign w_tab = {5'd0, atan_entry(r_step)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_step  <= '0;
                r_z     <= '0;
                r_x     <= i_dx[32] ? -{{3{i_dx[32]}}, i_dx} : {{3{i_dx[32]}}, i_dx};
                r_y     <= i_dy[32] ? -{{3{i_dy[32]}}, i_dy} : {{3{i_dy[32]}}, i_dy};
                r_dxneg <= i_dx[32];
                r_dyneg <= i_dy[32];
                r_zero  <= (i_dx == '0) && (i_dy == '0);
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_tab;
                end else if (r_y < 0) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_tab;
                end
                if (r_step == 4'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 4'd1;
            end
        end
    end

    always_comb begin
        if (r_z < 0) begin
            w_zc = '0;
        end else if (r_z > HALF_PI_Q) begin
            w_zc = HALF_PI_Q;
        end else begin
            w_zc = r_z;
        end
        if (r_zero) begin
            o_bearing = '0;
        end else if (!r_dxneg) begin
            o_bearing = r_dyneg ? -w_zc : w_zc;
        end else begin
            o_bearing = r_dyneg ? (w_zc - PI_Q) : (PI_Q - w_zc);
        end
    end

    assign o_done = r_done;
endmodule

### design/nearest_path_point_tracking_error.sv
// Load request: taken, written to the path memory, no result.
// Query request: scans N = clamp(path_length, 1, MAX_POINTS) entries one a cycle, drains
// the scan pipe, fetches the winner, then waits on the square root (the CORDIC runs
// alongside and is done sooner) and raises o_valid with the result.
// One request is worked on at a time: no request is taken until that result is taken.
// Reset (synchronous, active low) clears control state and sets path_length to 1024; the path
// memory is not cleared and must be loaded before it is queried.
module nearest_path_point_tracking_error
    import npte_pkg::*;
#(
    parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [LEN_W-1:0]    i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_operation,
    input  logic [IDX_W-1:0]    i_entry_index,
    input  logic signed [31:0]  i_point_x,
    input  logic signed [31:0]  i_point_y,
    input  logic signed [15:0]  i_point_heading,
    input  logic signed [31:0]  i_point_curvature,
    input  logic signed [31:0]  i_vehicle_x,
    input  logic signed [31:0]  i_vehicle_y,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_signed_error,
    output logic signed [31:0]  o_nearest_curvature,
    output logic signed [15:0]  o_nearest_heading,
    output logic [IDX_W-1:0]    o_nearest_index
);
    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned CW = AW + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_FETCH = 6'b000100,
        S_CALC  = 6'b001000,
        S_WAIT  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    logic [LEN_W-1:0] r_len;
    logic [CW-1:0]    r_addr;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_n;
    logic             r_rvalid;
    logic [CW-1:0]    r_ridx;
    logic             r_have;
    logic signed [31:0] r_vx;
    logic signed [31:0] r_vy;
    logic [66:0]      r_best;
    logic [CW-1:0]    r_bidx;
    logic signed [32:0] r_bdx;
    logic signed [32:0] r_bdy;
    logic [31:0]      r_sq_a;
    logic [31:0]      r_sq_b;
    logic signed [32:0] r_dx_s;
    logic signed [32:0] r_dy_s;
    logic [CW-1:0]    r_idx_s;
    logic             r_sv;
    logic [65:0]      r_dx2;
    logic [65:0]      r_dy2;
    logic signed [32:0] r_dx_p;
    logic signed [32:0] r_dy_p;
    logic [CW-1:0]    r_idx_p;
    logic             r_pv;
    logic             r_sq_done;
    logic             r_co_done;
    logic [30:0]      r_root;
    logic             r_sat;
    logic signed [17:0] r_bear;
    logic             r_ov;
    logic signed [31:0] r_err;
    logic signed [31:0] r_curv;
    logic signed [15:0] r_head;
    logic [IDX_W-1:0] r_oidx;

    logic [ENTRY_W-1:0] w_rdata;
    logic [AW-1:0]      w_raddr;
    logic               w_we;
    logic               w_acc;
    logic [CW-1:0]      w_nclamp;
    logic signed [32:0] w_dx;
    logic signed [32:0] w_dy;
    logic [66:0]        w_sum;
    logic               w_sq_done;
    logic [30:0]        w_root;
    logic               w_co_done;
    logic signed [17:0] w_bear;
    logic signed [17:0] w_diff;
    logic signed [17:0] w_wrap;
    logic [31:0]        w_mag;

    assign w_acc = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || r_ov;
    assign w_we = w_acc && (i_operation == OP_LOAD)
        && (32'(i_entry_index) < 32'(MAX_POINTS));

    always_comb begin
        if (r_len == '0) begin
            w_nclamp = CW'(1);
        end else if ({21'd0, r_len} > 32'(MAX_POINTS)) begin
            w_nclamp = CW'(MAX_POINTS);
        end else begin
            w_nclamp = CW'(r_len);
        end
    end

    // Outside the scan the memory keeps reading the winning entry.
    assign w_raddr = (r_state == S_SCAN) ? r_addr[AW-1:0] : r_bidx[AW-1:0];

    npte_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(AW'(i_entry_index)),
        .i_wdata({i_point_x, i_point_y, i_point_heading, i_point_curvature}),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_dx = 33'(signed'(w_rdata[111:80])) - 33'(r_vx);
    assign w_dy = 33'(signed'(w_rdata[79:48])) - 33'(r_vy);
    assign w_sum = {1'b0, r_dx2} + {1'b0, r_dy2};

    npte_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == S_FETCH),
        .i_value(r_best[61:0]),
        .o_done (w_sq_done),
        .o_root (w_root)
    );

    npte_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_FETCH),
        .i_dx     (r_bdx),
        .i_dy     (r_bdy),
        .o_done   (w_co_done),
        .o_bearing(w_bear)
    );

    assign w_diff = 18'(signed'(w_rdata[47:32])) - r_bear;
    always_comb begin
        if (w_diff > PI_Q) begin
            w_wrap = w_diff - TWO_PI_Q;
        end else if (w_diff <= -PI_Q) begin
            w_wrap = w_diff + TWO_PI_Q;
        end else begin
            w_wrap = w_diff;
        end
    end
    assign w_mag = r_sat ? 32'h7FFF_FFFF : {1'b0, r_root};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= LEN_W'(1024);
            r_rvalid  <= 1'b0;
            r_sv      <= 1'b0;
            r_pv      <= 1'b0;
            r_have    <= 1'b0;
            r_ov      <= 1'b0;
            r_sq_done <= 1'b0;
            r_co_done <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            // Scan pipe: memory read, difference, square, compare.
            r_rvalid <= (r_state == S_SCAN) && (r_addr < r_n);
            r_ridx   <= r_addr;
            r_sv     <= r_rvalid;
            r_dx_s   <= w_dx;
            r_dy_s   <= w_dy;
            r_sq_a   <= w_dx[32] ? 32'(-w_dx) : w_dx[31:0];
            r_sq_b   <= w_dy[32] ? 32'(-w_dy) : w_dy[31:0];
            r_idx_s  <= r_ridx;
            r_pv     <= r_sv;
            r_dx2    <= {2'b00, {32'd0, r_sq_a} * {32'd0, r_sq_a}};
            r_dy2    <= {2'b00, {32'd0, r_sq_b} * {32'd0, r_sq_b}};
            r_dx_p   <= r_dx_s;
            r_dy_p   <= r_dy_s;
            r_idx_p  <= r_idx_s;
            if (r_pv && (!r_have || w_sum < r_best)) begin
                r_have <= 1'b1;
                r_best <= w_sum;
                r_bidx <= r_idx_p;
                r_bdx  <= r_dx_p;
                r_bdy  <= r_dy_p;
            end
            if (w_sq_done) begin
                r_sq_done <= 1'b1;
                r_root    <= w_root;
            end
            if (w_co_done) begin
                r_co_done <= 1'b1;
                r_bear    <= w_bear;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && i_operation == OP_QUERY) begin
                        r_state <= S_SCAN;
                        r_addr  <= '0;
                        r_count <= '0;
                        r_n     <= w_nclamp;
                        r_vx    <= i_vehicle_x;
                        r_vy    <= i_vehicle_y;
                        r_have  <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (r_addr < r_n) begin
                        r_addr <= r_addr + CW'(1);
                    end else begin
                        r_count <= r_count + CW'(1);
                        if (r_count == CW'(3)) begin
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    r_sat     <= (r_best[66:62] != '0);
                    r_sq_done <= 1'b0;
                    r_co_done <= 1'b0;
                    r_state   <= S_CALC;
                end
                S_CALC: begin
                    if (r_sq_done && r_co_done) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_err   <= (w_wrap < 0) ? -signed'(w_mag) : signed'(w_mag);
                    r_curv  <= signed'(w_rdata[31:0]);
                    r_head  <= signed'(w_rdata[47:32]);
                    r_oidx  <= IDX_W'(r_bidx);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid             = r_ov;
    assign o_signed_error      = r_err;
    assign o_nearest_curvature = r_curv;
    assign o_nearest_heading   = r_head;
    assign o_nearest_index     = r_oidx;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !w_acc) else $error("request taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> (r_ov && $stable(r_err))) else $error("result lost");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= r_n)) else $error("scan overran");
`endif
endmodule

### verif/nearest_path_point_tracking_error_checker.sv
`timescale 1ns / 1ps

module nearest_path_point_tracking_error_checker
    import npte_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LEN_W-1:0]   i_cfg_wdata,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic               i_operation,
    input  logic [IDX_W-1:0]   i_entry_index,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [15:0] i_point_heading,
    input  logic signed [31:0] i_point_curvature,
    input  logic signed [31:0] i_vehicle_x,
    input  logic signed [31:0] i_vehicle_y,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [31:0] o_signed_error,
    input  logic signed [31:0] o_nearest_curvature,
    input  logic signed [15:0] o_nearest_heading,
    input  logic [IDX_W-1:0]   o_nearest_index,
    output int                 o_mismatches,
    output int                 o_pending
);
    typedef struct packed {
        logic signed [31:0] err;
        logic signed [31:0] curv;
        logic signed [15:0] head;
        logic [IDX_W-1:0]   idx;
    } t_tracking_result;

    logic signed [31:0] path_x [MAX_POINTS_DEF];
    logic signed [31:0] path_y [MAX_POINTS_DEF];
    logic signed [15:0] path_head [MAX_POINTS_DEF];
    logic signed [31:0] path_curv [MAX_POINTS_DEF];
    logic [LEN_W-1:0]   scan_len;
    t_tracking_result   expected_results[$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC on the magnitudes, then mapped back to the quadrant.
    function automatic longint bearing(input longint dx, input longint dy);
        longint x, y, z, xs, ys;
        if (dx == 0 && dy == 0) return 0;
        x = dx < 0 ? -dx : dx;
        y = dy < 0 ? -dy : dy;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + longint'(atan_entry(4'(i)));
            end else if (y < 0) begin
                x = x - ys; y = y + xs; z = z - longint'(atan_entry(4'(i)));
            end
        end
        if (z < 0) z = 0;
        if (z > longint'(HALF_PI_Q)) z = longint'(HALF_PI_Q);
        if (dx >= 0) return dy >= 0 ? z : -z;
        return dy >= 0 ? longint'(PI_Q) - z : z - longint'(PI_Q);
    endfunction

    function automatic t_tracking_result nearest_point(input logic signed [31:0] vx,
                                                       input logic signed [31:0] vy);
        t_tracking_result r;
        int n, best;
        longint dx, dy, bdx, bdy, distance, diff;
        logic [65:0] ax, ay, sq, best_sq;
        n = scan_len == 0 ? 1 : (scan_len > MAX_POINTS_DEF ? MAX_POINTS_DEF : scan_len);
        best = 0; best_sq = 0; bdx = 0; bdy = 0;
        for (int i = 0; i < n; i++) begin
            dx = longint'(path_x[i]) - longint'(vx);
            dy = longint'(path_y[i]) - longint'(vy);
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            sq = ax * ax + ay * ay;
            if (i == 0 || sq < best_sq) begin
                best_sq = sq; best = i; bdx = dx; bdy = dy;
            end
        end
        if (best_sq >= (66'd1 << 62)) distance = 32'h7FFFFFFF;
        else distance = longint'(int_sqrt(best_sq[63:0]));
        diff = longint'(path_head[best]) - bearing(bdx, bdy);
        if (diff > longint'(PI_Q)) diff = diff - longint'(TWO_PI_Q);
        else if (diff <= -longint'(PI_Q)) diff = diff + longint'(TWO_PI_Q);
        if (diff < 0) distance = -distance;
        r.err = distance[31:0];
        r.curv = path_curv[best];
        r.head = path_head[best];
        r.idx = best[IDX_W-1:0];
        return r;
    endfunction

    initial begin
        o_mismatches = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_tracking_result want;
        if (!i_rst_n) begin
            scan_len = 11'd1024;
        end else begin
            if (i_cfg_we) scan_len = i_cfg_wdata;
            if (i_valid && !o_stall) begin
                if (i_operation == OP_LOAD) begin
                    path_x[i_entry_index] = i_point_x;
                    path_y[i_entry_index] = i_point_y;
                    path_head[i_entry_index] = i_point_heading;
                    path_curv[i_entry_index] = i_point_curvature;
                end else begin
                    expected_results = {expected_results,
                                        nearest_point(i_vehicle_x, i_vehicle_y)};
                end
            end
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: expected no result, actual err %0d idx %0d",
                             $time, o_signed_error, o_nearest_index);
                    o_mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_signed_error !== want.err || o_nearest_curvature !== want.curv ||
                        o_nearest_heading !== want.head || o_nearest_index !== want.idx) begin
                        $display("%0t: expected err %0d curv %0d head %0d idx %0d",
                                 $time, want.err, want.curv, want.head, want.idx);
                        $display("%0t: actual   err %0d curv %0d head %0d idx %0d",
                                 $time, o_signed_error, o_nearest_curvature,
                                 o_nearest_heading, o_nearest_index);
                        o_mismatches++;
                    end
                end
            end
            o_pending = expected_results.size();
        end
    end
endmodule

### verif/nearest_path_point_tracking_error_tb.sv
`timescale 1ns / 1ps

module nearest_path_point_tracking_error_tb;
    import npte_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [LEN_W-1:0]   i_cfg_wdata;
    logic               i_valid;
    logic               o_stall;
    logic               i_operation;
    logic [IDX_W-1:0]   i_entry_index;
    logic signed [31:0] i_point_x;
    logic signed [31:0] i_point_y;
    logic signed [15:0] i_point_heading;
    logic signed [31:0] i_point_curvature;
    logic signed [31:0] i_vehicle_x;
    logic signed [31:0] i_vehicle_y;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_signed_error;
    logic signed [31:0] o_nearest_curvature;
    logic signed [15:0] o_nearest_heading;
    logic [IDX_W-1:0]   o_nearest_index;
    int                 mismatches;
    int                 pending;
    int                 cycles;
    bit                 idling;
    int                 stall_left;
    int                 free_left;

    // Stimulus-side copy of the path, used to aim queries and make ties.
    logic signed [31:0] near_x [MAX_POINTS_DEF];
    logic signed [31:0] near_y [MAX_POINTS_DEF];
    bit                 written [MAX_POINTS_DEF];

    nearest_path_point_tracking_error u_dut (.*);

    nearest_path_point_tracking_error_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata, .i_valid, .o_stall, .i_operation,
        .i_entry_index, .i_point_x, .i_point_y, .i_point_heading, .i_point_curvature,
        .i_vehicle_x, .i_vehicle_y, .o_valid, .i_stall, .o_signed_error,
        .o_nearest_curvature, .o_nearest_heading, .o_nearest_index,
        .o_mismatches(mismatches), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!idling) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (free_left > 0) begin
            free_left--;
            i_stall <= 1'b0;
        end else begin
            stall_left = $urandom_range(0, 6);
            free_left = $urandom_range(1, 20);
            i_stall <= 1'b1;
        end
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2, 3, 4: return $urandom;
            default: return $signed($urandom_range(0, 2097152)) - 1048576;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_heading();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 51472)) - 25736);
    endfunction

    task automatic send_request(input logic op, input logic [IDX_W-1:0] idx,
                                input logic signed [31:0] px, input logic signed [31:0] py,
                                input logic signed [15:0] ph, input logic signed [31:0] pc,
                                input logic signed [31:0] vx, input logic signed [31:0] vy);
        if (idling && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_entry_index <= idx;
        i_point_x <= px;
        i_point_y <= py;
        i_point_heading <= ph;
        i_point_curvature <= pc;
        i_vehicle_x <= vx;
        i_vehicle_y <= vy;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        if (op == OP_LOAD) begin
            near_x[idx] = px;
            near_y[idx] = py;
            written[idx] = 1'b1;
        end
    endtask

    task automatic load_point(input logic [IDX_W-1:0] idx, input logic signed [31:0] px,
                              input logic signed [31:0] py, input logic signed [15:0] ph,
                              input logic signed [31:0] pc);
        send_request(OP_LOAD, idx, px, py, ph, pc, $urandom, $urandom);
    endtask

    task automatic query_at(input logic signed [31:0] vx, input logic signed [31:0] vy);
        send_request(OP_QUERY, IDX_W'($urandom), $urandom, $urandom, 16'($urandom),
                     $urandom, vx, vy);
    endtask

    // Length writes happen only with the block drained and quiet.
    task automatic set_length(input logic [LEN_W-1:0] len);
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= len;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] len, input int count);
        int n, k;
        logic signed [31:0] vx, vy;
        set_length(len);
        n = len == 0 ? 1 : (len > MAX_POINTS_DEF ? MAX_POINTS_DEF : len);
        for (int i = 0; i < n; i++)
            if (!written[i])
                load_point(IDX_W'(i), rand_coord(), rand_coord(), rand_heading(), $urandom);
        for (int j = 0; j < count; j++) begin
            k = $urandom_range(0, n - 1);
            if ($urandom_range(0, 9) < 4) begin
                if ($urandom_range(0, 9) < 7) k = $urandom_range(0, n - 1);
                else k = $urandom_range(0, MAX_POINTS_DEF - 1);
                if ($urandom_range(0, 4) == 0) begin
                    load_point(IDX_W'(k), near_x[$urandom_range(0, n - 1)],
                               near_y[$urandom_range(0, n - 1)], rand_heading(), $urandom);
                end else begin
                    load_point(IDX_W'(k), rand_coord(), rand_coord(), rand_heading(),
                               $urandom);
                end
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin vx = near_x[k]; vy = near_y[k]; end
                    3, 4: begin
                        vx = near_x[k] + $signed($urandom_range(0, 200)) - 100;
                        vy = near_y[k] + $signed($urandom_range(0, 200)) - 100;
                    end
                    default: begin vx = rand_coord(); vy = rand_coord(); end
                endcase
                query_at(vx, vy);
            end
        end
    endtask

    initial begin
        cycles = 0;
        idling = 1'b1;
        stall_left = 0;
        free_left = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_operation = OP_LOAD;
        i_entry_index = '0;
        i_point_x = '0;
        i_point_y = '0;
        i_point_heading = '0;
        i_point_curvature = '0;
        i_vehicle_x = '0;
        i_vehicle_y = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: a length of zero scans only the first entry.
        set_length(11'd0);
        load_point(0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sd25736, 32'sh7FFFFFFF);
        query_at(32'sh80000000, 32'sh80000000);
        query_at(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        query_at(32'sh80000000, 32'sh7FFFFFFF);
        load_point(0, 32'sh80000000, 32'sh80000000, -16'sd25736, 32'sh80000000);
        query_at(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        query_at(32'sh7FFFFFFF, 32'sh80000000);
        query_at(32'sh80000000, 32'sh80000000);
        load_point(1023, 32'sh12345678, -32'sh00ABCDEF, 16'sd100, 32'sh00010000);
        load_point(0, 32'sh00010000, 32'sh00010000, 16'sh7FFF, -32'sh00020000);
        query_at(32'sh00000000, 32'sh00000000);
        query_at(32'sh00020000, 32'sh00000000);
        query_at(32'sh00020000, 32'sh00020000);
        query_at(32'sh00000000, 32'sh00020000);
        load_point(0, 32'sh00010000, 32'sh00010000, 16'sh8000, 32'sh0);
        query_at(32'sh00010000, 32'sh00030000);
        query_at(32'sh00030000, 32'sh00000000);
        load_point(0, 32'sh00000000, -32'sh00050000, 16'sd0, 32'sh00000001);
        query_at(32'sh00000005, -32'sh00050000);
        query_at(32'sh00000000, -32'sh00050000);

        run_phase(11'd1, 60);
        run_phase(11'd7, 80);
        run_phase(11'd3, 80);
        run_phase(11'd16, 80);
        run_phase(11'd100, 30);
        idling = 1'b0;
        run_phase(11'd2, 80);

        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
